[hdl/sbl_pkg.sv]
package sbl_pkg;

    localparam int MAX_RADIUS_DEF = 63;
    localparam int CH_W           = 8;
    localparam int SUM_W          = 21;
    localparam int RAD_W          = 6;
    localparam int MUL_W          = 10;
    localparam int SHF_W          = 5;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    localparam logic [PADDR_W-3:0] REG_RADIUS = 2'd0;
    localparam logic [PADDR_W-3:0] REG_MULT   = 2'd1;
    localparam logic [PADDR_W-3:0] REG_SHIFT  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 6'd1;
    localparam logic [MUL_W-1:0] MULT_RST   = 10'd512;
    localparam logic [SHF_W-1:0] SHIFT_RST  = 5'd11;

    typedef struct packed {
        logic load;
        logic clear_line;
        logic init_tap;
        logic issue;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic emit_cond;
        logic line_end;
        logic last_tap;
        logic out_free;
    } t_stat;

endpackage

[hdl/sbl_if.sv]
interface sbl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
    logic [7:0] chan_alpha;
    logic       line_end;

    modport source (output valid, chan_blue, chan_green, chan_red, chan_alpha, line_end,
                    input ready);
    modport sink   (input valid, chan_blue, chan_green, chan_red, chan_alpha, line_end,
                    output ready);
endinterface

interface sbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       out_line_end;

    modport source (output valid, out_blue, out_green, out_red, out_alpha, out_line_end,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_alpha, out_line_end,
                    output ready);
endinterface

[hdl/stack_blur_line_pass.sv]
// One-dimensional stack blur over a line of 4x8-bit pixels. Pixels enter on s_pix, one
// per transfer, with line_end on the last pixel of a line; blurred pixels leave on m_out
// in line order, the first once radius pixels of lookahead have arrived, the rest of the
// line flushed after the line_end pixel. Edges repeat the first and last pixel. Each
// channel sum is scaled as (sum * scale_multiplier) >> scale_shift and saturated to 255;
// radius zero passes pixels through. No new input pixel is taken until every blurred
// pixel it releases is emitted; for each of those the window taps are read one per
// cycle from a single-port pixel memory of 2^ceil(log2(2*MAX_RADIUS+1)) entries.
// Registers: radius at 0x0, multiplier at 0x4, shift at 0x8; write only while idle.
module stack_blur_line_pass
    import sbl_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sbl_pix_if.sink            s_pix,
    sbl_out_if.source          m_out
);
    logic [RAD_W-1:0] radius;
    logic [MUL_W-1:0] mult;
    logic [SHF_W-1:0] shift;
    t_cmd             cmd;
    t_stat            stat;
    logic             in_ready;

    sbl_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_radius (radius),
        .o_mult   (mult),
        .o_shift  (shift)
    );

    sbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_pix.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sbl_dp #(.MAX_RADIUS(MAX_RADIUS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_ready (in_ready),
        .o_stat     (stat),
        .i_radius   (radius),
        .i_mult     (mult),
        .i_shift    (shift),
        .s_pix      (s_pix),
        .m_out      (m_out)
    );
endmodule

[hdl/sbl_cfg.sv]
module sbl_cfg
    import sbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [RAD_W-1:0]   o_radius,
    output logic [MUL_W-1:0]   o_mult,
    output logic [SHF_W-1:0]   o_shift
);
    logic [RAD_W-1:0]   r_radius;
    logic [MUL_W-1:0]   r_mult;
    logic [SHF_W-1:0]   r_shift;
    logic               wr;
    logic [PADDR_W-3:0] idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_mult   <= MULT_RST;
            r_shift  <= SHIFT_RST;
        end else if (wr) begin
            case (idx)
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_MULT:   r_mult   <= pwdata[MUL_W-1:0];
                REG_SHIFT:  r_shift  <= pwdata[SHF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RADIUS: prdata = PDATA_W'(r_radius);
            REG_MULT:   prdata = PDATA_W'(r_mult);
            REG_SHIFT:  prdata = PDATA_W'(r_shift);
            default:    prdata = '0;
        endcase
    end

    assign o_radius = r_radius;
    assign o_mult   = r_mult;
    assign o_shift  = r_shift;
endmodule

[hdl/sbl_ctrl.sv]
module sbl_ctrl
    import sbl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_TAP   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.emit_cond) begin
                    o_cmd.init_tap = 1'b1;
                    n_state        = S_TAP;
                end else begin
                    o_cmd.clear_line = i_stat.line_end;
                    n_state          = S_IDLE;
                end
            end
            S_TAP: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[hdl/sbl_dp.sv]
module sbl_dp
    import sbl_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_in_ready,
    output t_stat            o_stat,
    input  logic [RAD_W-1:0] i_radius,
    input  logic [MUL_W-1:0] i_mult,
    input  logic [SHF_W-1:0] i_shift,
    sbl_pix_if.sink          s_pix,
    sbl_out_if.source        m_out
);
    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW        = $clog2(WIN_DEPTH);
    localparam int MEM_D     = 1 << AW;
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int PW        = $clog2(MAX_RADIUS + 2);
    localparam int OW        = RW + 2;
    localparam int PRD_W     = SUM_W + MUL_W;

    logic [4*CH_W-1:0] r_mem [MEM_D];
    logic [AW-1:0]     r_wp;
    logic [AW:0]       r_pos;
    logic [AW:0]       r_n;
    logic [PW-1:0]     r_pend;
    logic              r_end;
    logic signed [RW:0] r_k;
    logic              r_tv;
    logic [RW:0]       r_w;
    logic [4*CH_W-1:0] r_rd;
    logic [SUM_W-1:0]  r_acc [4];
    logic [PRD_W-1:0]  r_prod [4];
    logic              r_ov;
    logic [CH_W-1:0]   r_och [4];
    logic              r_ole;

    logic [RW-1:0]        rad;
    logic [RW-1:0]        d;
    logic signed [OW-1:0] off_s;
    logic [AW:0]          off;
    logic [RW-1:0]        kabs;
    logic [RW:0]          w;
    logic [AW-1:0]        rd_addr;
    logic [4*CH_W-1:0]    pix;
    logic                 out_free;

    always_comb begin
        if (i_radius > RAD_W'(MAX_RADIUS)) begin
            rad = RW'(MAX_RADIUS);
        end else begin
            rad = i_radius[RW-1:0];
        end
    end

    assign d    = RW'(r_pend - PW'(1));
    assign pix  = {s_pix.chan_alpha, s_pix.chan_red, s_pix.chan_green, s_pix.chan_blue};
    assign kabs = r_k[RW] ? RW'(-r_k) : r_k[RW-1:0];
    assign w    = (RW+1)'(rad) + (RW+1)'(1) - (RW+1)'(kabs);

    // tap offset behind the newest pixel, clamped to the line start and window
    always_comb begin
        off_s = $signed({2'b00, d}) - OW'(r_k);
        if (off_s < 0) begin
            off = '0;
        end else begin
            off = (AW+1)'(off_s);
        end
        if (off > r_n) begin
            off = r_n;
        end
        if (off > (AW+1)'(WIN_DEPTH - 1)) begin
            off = (AW+1)'(WIN_DEPTH - 1);
        end
    end

    assign rd_addr  = r_wp - off[AW-1:0];
    assign out_free = !r_ov || m_out.ready;

    assign o_stat.emit_cond = (r_pend != '0) && (r_end || ((r_pend - PW'(1)) >= PW'(rad)));
    assign o_stat.line_end  = r_end;
    assign o_stat.last_tap  = (r_k == $signed({1'b0, rad}));
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_wp + AW'(1)] <= pix;
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_pos  <= '0;
            r_pend <= '0;
            r_end  <= 1'b0;
            r_tv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_tv <= i_cmd.issue;
            if (i_cmd.load) begin
                r_wp  <= r_wp + AW'(1);
                r_n   <= r_pos;
                r_end <= s_pix.line_end;
                if (r_pos < (AW+1)'(WIN_DEPTH)) begin
                    r_pos <= r_pos + (AW+1)'(1);
                end
                if (r_pend < PW'(MAX_RADIUS + 1)) begin
                    r_pend <= r_pend + PW'(1);
                end
            end
            if (i_cmd.clear_line) begin
                r_pos  <= '0;
                r_pend <= '0;
            end
            if (i_cmd.emit) begin
                r_pend <= r_pend - PW'(1);
                r_ov   <= 1'b1;
                r_ole  <= r_end && (r_pend == PW'(1));
            end else if (m_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_tap) begin
            r_k <= -$signed({1'b0, rad});
        end else if (i_cmd.issue) begin
            r_k <= r_k + (RW+1)'(1);
        end
        if (i_cmd.issue) begin
            r_w <= w;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_ch
        logic [PRD_W-1:0] sh;

        always_ff @(posedge i_clk) begin
            if (i_cmd.init_tap) begin
                r_acc[c] <= '0;
            end else if (r_tv) begin
                r_acc[c] <= r_acc[c] + SUM_W'(r_w * r_rd[c*CH_W +: CH_W]);
            end
            if (i_cmd.mul) begin
                r_prod[c] <= PRD_W'(r_acc[c]) * PRD_W'(i_mult);
            end
        end

        assign sh = r_prod[c] >> i_shift;

        always_ff @(posedge i_clk) begin
            if (i_cmd.emit) begin
                if (rad == '0) begin
                    r_och[c] <= r_acc[c][CH_W-1:0];
                end else if (|sh[PRD_W-1:CH_W]) begin
                    r_och[c] <= '1;
                end else begin
                    r_och[c] <= sh[CH_W-1:0];
                end
            end
        end
    end

    assign s_pix.ready        = i_in_ready;
    assign m_out.valid        = r_ov;
    assign m_out.out_blue     = r_och[0];
    assign m_out.out_green    = r_och[1];
    assign m_out.out_red      = r_och[2];
    assign m_out.out_alpha    = r_och[3];
    assign m_out.out_line_end = r_ole;
endmodule

[hdl/sbl_chk.sv]
module sbl_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_blue
);
    // ready only in the idle state, never two transfers back to back
    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("input taken while busy");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("output dropped");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> $stable(out_blue)) else $error("output changed");
endmodule

bind stack_blur_line_pass sbl_chk u_sbl_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .pready    (pready),
    .in_valid  (s_pix.valid),
    .in_ready  (s_pix.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_blue  (m_out.out_blue)
);
